[hw/rtl/fpmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_pkg
// shared types and constants of the fixed-point multiply/divide unit
// ----------------------------------------------------------------------------
package fpmd_pkg;

  localparam int DefaultFracBits = 8;
  // widest dividend: a 32-bit magnitude shifted by the largest fraction count
  localparam int DVD_W     = 47;
  localparam int DIV_STEPS = DVD_W;
  localparam int WORK_W    = 32 + DVD_W;

  typedef enum logic [2:0] {
    OP_MUL16_Q8 = 3'd0,
    OP_MUL16_SH = 3'd1,
    OP_MUL32_Q8 = 3'd2,
    OP_DIV16_Q8 = 3'd3,
    OP_DIV16_SH = 3'd4,
    OP_DIV32_Q8 = 3'd5,
    OP_INV16_Q8 = 3'd6,
    OP_INV16_SH = 3'd7
  } op_t;

  // work: for multiplies {a, b} then the product, for divides {remainder, dividend/quotient}
  typedef struct packed {
    logic              is_mul;
    logic              is16;
    logic              neg;
    logic              dz;
    logic [3:0]        k;
    logic [31:0]       dvs;
    logic [WORK_W-1:0] work;
  } dec_t;

endpackage

[hw/rtl/fpmd_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd interfaces
// request, decoded-item and response channels
// ----------------------------------------------------------------------------
interface fpmd_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [3:0]         shift_amount;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source(output valid, opcode, shift_amount, operand_a, operand_b, input ready);
  modport sink(input valid, opcode, shift_amount, operand_a, operand_b, output ready);
endinterface

interface fpmd_dec_if import fpmd_pkg::*; ;
  logic valid;
  logic ready;
  dec_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface fpmd_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               divide_by_zero;
  modport source(output valid, result, divide_by_zero, input ready);
  modport sink(input valid, result, divide_by_zero, output ready);
endinterface

[hw/rtl/fpmd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_front
// accepts requests, decodes the opcode and prepares operands and magnitudes
// ----------------------------------------------------------------------------
module fpmd_front import fpmd_pkg::*; #(
  parameter int FRAC_BITS = DefaultFracBits
) (
  input logic       clk,
  input logic       rst,
  fpmd_req_if.sink  req,
  fpmd_dec_if.source dec
);

  op_t         op;
  logic        is16, is_mul, is_inv, is_sh;
  logic [31:0] av, bv, a_mag, b_mag, num_mag;
  logic [DVD_W-1:0] dvd;
  dec_t        d;

  always_comb begin
    op = op_t'(req.opcode);
    is_mul = 1'b0;
    is_inv = 1'b0;
    is_sh  = 1'b0;
    unique case (op)
      OP_MUL16_Q8, OP_MUL32_Q8: is_mul = 1'b1;
      OP_MUL16_SH: begin
        is_mul = 1'b1;
        is_sh  = 1'b1;
      end
      OP_DIV16_Q8, OP_DIV32_Q8: ;
      OP_DIV16_SH: is_sh = 1'b1;
      OP_INV16_Q8: is_inv = 1'b1;
      OP_INV16_SH: begin
        is_inv = 1'b1;
        is_sh  = 1'b1;
      end
      default: ;
    endcase
    is16 = (op != OP_MUL32_Q8) && (op != OP_DIV32_Q8);
    av = is16 ? {{16{req.operand_a[15]}}, req.operand_a[15:0]} : req.operand_a;
    bv = is16 ? {{16{req.operand_b[15]}}, req.operand_b[15:0]} : req.operand_b;
    a_mag = av[31] ? (32'd0 - av) : av;
    b_mag = bv[31] ? (32'd0 - bv) : bv;
    num_mag = is_inv ? 32'h100 : a_mag;
    d.k   = is_sh ? req.shift_amount : FRAC_BITS[3:0];
    dvd   = {{(DVD_W-32){1'b0}}, num_mag} << d.k;
    d.is_mul = is_mul;
    d.is16   = is16;
    d.neg    = is_inv ? bv[31] : (av[31] ^ bv[31]);
    d.dz     = !is_mul && (bv == 32'd0);
    d.dvs    = b_mag;
    d.work   = is_mul ? {{(WORK_W-64){1'b0}}, av, bv} : {32'd0, dvd};
  end

  assign req.ready = !dec.valid || dec.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else if (req.ready) begin
      dec.valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      dec.data <= d;
    end
  end

endmodule

[hw/rtl/fpmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_queue
// two-entry queue between decode and execution
// ----------------------------------------------------------------------------
module fpmd_queue import fpmd_pkg::*; (
  input logic        clk,
  input logic        rst,
  fpmd_dec_if.sink   wr,
  fpmd_dec_if.source rd
);

  dec_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       push, pop;

  assign wr.ready = (cnt != 2'd2);
  assign rd.valid = (cnt != 2'd0);
  assign rd.data  = mem[rptr];
  assign push = wr.valid && wr.ready;
  assign pop  = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem[wptr] <= wr.data;
    end
  end

endmodule

[hw/rtl/fpmd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_back
// execution pipeline: multiply and scale, or one quotient bit per stage
// ----------------------------------------------------------------------------
module fpmd_back import fpmd_pkg::*; (
  input logic       clk,
  input logic       rst,
  fpmd_dec_if.sink  src,
  fpmd_rsp_if.source rsp
);

  dec_t st  [DIV_STEPS+1];
  dec_t nxt [DIV_STEPS];
  logic vld [DIV_STEPS+1];
  logic en;

  function automatic dec_t step(dec_t d, int idx);
    dec_t        o;
    logic signed [63:0] p;
    logic [63:0] bias;
    logic [32:0] t, diff;
    logic        ge;
    o = d;
    if (d.is_mul) begin
      if (idx == 0) begin
        p = $signed(d.work[63:32]) * $signed(d.work[31:0]);
        o.work = {{(WORK_W-64){1'b0}}, p};
      end else if (idx == 1) begin
        p = $signed(d.work[63:0]);
        // bias negative products so the shift truncates toward zero
        bias = p[63] ? ((64'd1 << d.k) - 64'd1) : 64'd0;
        p = $signed(p + bias) >>> d.k;
        o.work = {{(WORK_W-64){1'b0}}, p};
      end
    end else begin
      t    = {d.work[WORK_W-1 -: 32], d.work[DVD_W-1]};
      diff = t - {1'b0, d.dvs};
      ge   = (t >= {1'b0, d.dvs});
      o.work[WORK_W-1 -: 32] = ge ? diff[31:0] : t[31:0];
      o.work[DVD_W-1:0]      = {d.work[DVD_W-2:0], ge};
    end
    return o;
  endfunction

  assign en = !rsp.valid || rsp.ready;
  assign src.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= src.valid;
    end
    if (en) begin
      st[0] <= src.data;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
    always_comb nxt[i] = step(st[i], i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        st[i+1] <= nxt[i];
      end
    end
  end

  dec_t        fin;
  logic [31:0] val, res;

  always_comb begin
    fin = st[DIV_STEPS];
    if (fin.is_mul) begin
      val = fin.work[31:0];
    end else if (fin.dz) begin
      val = 32'd0;
    end else begin
      val = fin.neg ? (32'd0 - fin.work[31:0]) : fin.work[31:0];
    end
    res = fin.is16 ? {{16{val[15]}}, val[15:0]} : val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= vld[DIV_STEPS];
    end
    if (en) begin
      rsp.result         <= res;
      rsp.divide_by_zero <= !fin.is_mul && fin.dz;
    end
  end

endmodule

[hw/rtl/fixed_point_mul_div_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_mul_div_unit
// eight fixed-point multiply, divide and inverse operations
// ----------------------------------------------------------------------------
// req carries opcode, shift_amount and two operands; rsp carries result and
// divide_by_zero, one response per request, in request order.
// A request is taken in every cycle while req.ready is high, so the sustained
// rate is one transaction per cycle.
// The path runs through one decode register, the two-entry queue, 48 pipeline
// registers set by the restoring divider that retires one quotient bit per
// stage, and the output register. Multiplies ride the same pipeline so that
// responses stay in order.
// When rsp.ready is low the whole execution pipeline holds; the queue keeps taking decoded
// requests until it is full, and req.ready falls once the decode register holds one too.
// A synchronous reset empties the pipeline and the queue; no state survives
// between transactions.
// ----------------------------------------------------------------------------
module fixed_point_mul_div_unit import fpmd_pkg::*; #(
  parameter int FRAC_BITS = DefaultFracBits
) (
  input logic       clk,
  input logic       rst,
  fpmd_req_if.sink  req,
  fpmd_rsp_if.source rsp
);

  fpmd_dec_if fq ();
  fpmd_dec_if qb ();

  fpmd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .req(req), .dec(fq)
  );

  fpmd_queue u_queue (
    .clk(clk), .rst(rst), .wr(fq), .rd(qb)
  );

  fpmd_back u_back (
    .clk(clk), .rst(rst), .src(qb), .rsp(rsp)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> rsp.result == 32'd0)
    else $error("divide by zero response with nonzero result");

  a_front_load: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> fq.valid)
    else $error("accepted request missing from decode register");

  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    fq.valid && !fq.ready |=> fq.valid && $stable(fq.data))
    else $error("decoded item lost while queue full");

endmodule
